### design/frwf_pkg.sv
// ----------------------------------------------------------------------------
// frwf_pkg - shared types and constants of the fault rate window filter
// Field widths, operation codes, register map, register reset values and the input word.
// ----------------------------------------------------------------------------
`default_nettype none

package frwf_pkg;

	localparam int OP_W       = 2;
	localparam int ID_IN_W    = 6;
	localparam int SEV_W      = 8;
	localparam int TIME_W     = 32;
	localparam int THR_W      = 5;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 8;
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;

	// operation codes
	localparam logic [OP_W-1:0] OP_REPORT  = 2'd0;
	localparam logic [OP_W-1:0] OP_CLR_ONE = 2'd1;
	localparam logic [OP_W-1:0] OP_CLR_ALL = 2'd2;

	// register indexes (byte address bits [3:2])
	localparam logic [1:0] REG_FILTER_EN = 2'd0;
	localparam logic [1:0] REG_BYPASS    = 2'd1;
	localparam logic [1:0] REG_THRESH    = 2'd2;
	localparam logic [1:0] REG_WINDOW    = 2'd3;

	localparam logic              RST_FILTER_EN = 1'b1;
	localparam logic [SEV_W-1:0]  RST_BYPASS    = 8'd255;
	localparam logic [THR_W-1:0]  RST_THRESH    = 5'd1;
	localparam logic [TIME_W-1:0] RST_WINDOW    = 32'd1000;

	// input word, first field in the highest bits
	typedef struct packed {
		logic [TIME_W-1:0]  now_ticks;
		logic [SEV_W-1:0]   severity;
		logic [ID_IN_W-1:0] fault_id;
		logic [OP_W-1:0]    op;
	} in_word_t;

endpackage

`default_nettype wire

### design/frwf_ram.sv
// ----------------------------------------------------------------------------
// frwf_ram - generic single-write, single-read RAM
// One write port and one read port, read data registered, old data on
// a read of the address being written in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module frwf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### design/fault_rate_window_filter_core.sv
// ----------------------------------------------------------------------------
// fault_rate_window_filter_core - per-fault-ID burst filter
// Forwards a fault report when filtering is off, when its severity reaches
// the bypass level, or when enough reports of that ID fall in the window.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one operation per word: report, clear one ID or clear all.
//   Only a report yields a word on m_axis, whose bit 0 says forward or drop.
//   Registers sit on the APB port: filter enable, bypass level, threshold
//   and window length. Any register write clears every ID's history; write
//   only while no word is in flight.
//   Throughput is one word per cycle while m_axis does not stall. A report
//   reaches m_axis through the count and ring pointer RAM read, then the
//   stamp RAM read, then the window compare, each registered. Back-to-back
//   words on the same ID are forwarded around the count RAM write.
//   A stall on m_axis holds every stage; s_axis_tready falls only while the
//   output word waits to be taken.
//   Reset restores the register defaults and invalidates every ID's count
//   at once through one valid flag per ID; no clearing pass is needed and
//   no stamp RAM word is used before it is written.
// ----------------------------------------------------------------------------
`default_nettype none

module fault_rate_window_filter_core #(
	parameter int NUM_IDS    = 64,
	parameter int MAX_THRESH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// op[1:0], fault_id[7:2], severity[15:8], now_ticks[47:16]
	input  logic [frwf_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// forward[0], zeros above
	output logic [frwf_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [frwf_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [frwf_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [frwf_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                             pready
);

	import frwf_pkg::*;

	localparam int ID_W     = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
	localparam int PTR_W    = (MAX_THRESH > 1) ? $clog2(MAX_THRESH) : 1;
	localparam int SEEN_W   = $clog2(MAX_THRESH + 1);
	localparam int META_W   = SEEN_W + PTR_W;
	localparam int ST_DEPTH = NUM_IDS * MAX_THRESH;
	localparam int ST_AW    = (ST_DEPTH > 1) ? $clog2(ST_DEPTH) : 1;
	localparam int CMP_W    = (SEEN_W > THR_W) ? SEEN_W : THR_W;
	localparam int WRAP_N   = 2 ** ID_IN_W;

	// configuration registers
	logic              filter_en_q;
	logic [SEV_W-1:0]  bypass_q;
	logic [THR_W-1:0]  thresh_q;
	logic [TIME_W-1:0] window_q;
	logic              cfg_wr;

	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_en_q <= RST_FILTER_EN;
			bypass_q    <= RST_BYPASS;
			thresh_q    <= RST_THRESH;
			window_q    <= RST_WINDOW;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_FILTER_EN: filter_en_q <= pwdata[0];
				REG_BYPASS:    bypass_q    <= pwdata[SEV_W-1:0];
				REG_THRESH:    thresh_q    <= pwdata[THR_W-1:0];
				REG_WINDOW:    window_q    <= pwdata[TIME_W-1:0];
				default:       filter_en_q <= filter_en_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_FILTER_EN: prdata = CFG_DATA_W'(filter_en_q);
			REG_BYPASS:    prdata = CFG_DATA_W'(bypass_q);
			REG_THRESH:    prdata = CFG_DATA_W'(thresh_q);
			REG_WINDOW:    prdata = CFG_DATA_W'(window_q);
			default:       prdata = '0;
		endcase
	end

	// ID wrap table
	logic [ID_W-1:0] id_wrap [WRAP_N];

	for (genvar g = 0; g < WRAP_N; g++) begin : g_wrap
		assign id_wrap[g] = ID_W'(g % NUM_IDS);
	end

	// handshake and stage advance
	logic     adv;
	logic     accept;
	in_word_t in_w;
	logic [ID_W-1:0] in_idx;
	logic     out_vld_q;
	logic     fwd_q;

	assign adv           = !out_vld_q || m_axis_tready;
	assign accept        = s_axis_tvalid && adv;
	assign s_axis_tready = adv;
	assign in_w          = s_axis_tdata;
	assign in_idx        = id_wrap[in_w.fault_id];

	// stage 1
	logic              vld_s1;
	logic [OP_W-1:0]   op_s1;
	logic [ID_W-1:0]   idx_s1;
	logic [SEV_W-1:0]  sev_s1;
	logic [TIME_W-1:0] now_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= in_w.op;
			idx_s1 <= in_idx;
			sev_s1 <= in_w.severity;
			now_s1 <= in_w.now_ticks;
		end
	end

	// per-ID count and ring pointer, with valid flags and a bypass of
	// the write made in the cycle of the read
	logic [META_W-1:0]  meta_rd;
	logic [META_W-1:0]  meta_cur;
	logic [META_W-1:0]  meta_new;
	logic [NUM_IDS-1:0] id_vld_q;
	logic               tag_vld_q;
	logic [ID_W-1:0]    tag_idx_q;
	logic [META_W-1:0]  tag_meta_q;
	logic [SEEN_W-1:0]  seen_cur;
	logic [SEEN_W-1:0]  seen_new;
	logic [PTR_W-1:0]   ptr_cur;
	logic [PTR_W-1:0]   ptr_new;
	logic [PTR_W-1:0]   back_ptr;
	logic [PTR_W-1:0]   thr_m1_p;
	logic [CMP_W-1:0]   thr_raw;
	logic [CMP_W-1:0]   thr_eff;
	logic               is_report;
	logic               filt;
	logic               track;
	logic               meta_we;
	logic               st_we;
	logic [ST_AW-1:0]   st_base;
	logic [ST_AW-1:0]   st_wr_addr;
	logic [ST_AW-1:0]   st_rd_addr;
	logic [TIME_W-1:0]  st_rd;
	logic               res_s1;
	logic               need_cmp_s1;

	frwf_ram #(
		.WIDTH (META_W),
		.DEPTH (NUM_IDS)
	) u_meta_ram (
		.clk     (clk),
		.wr_en   (meta_we),
		.wr_addr (idx_s1),
		.wr_data (meta_new),
		.rd_en   (accept),
		.rd_addr (in_idx),
		.rd_data (meta_rd)
	);

	always_comb begin
		if (tag_vld_q && tag_idx_q == idx_s1) begin
			meta_cur = tag_meta_q;
		end else if (id_vld_q[idx_s1]) begin
			meta_cur = meta_rd;
		end else begin
			meta_cur = '0;
		end
	end

	assign seen_cur = meta_cur[META_W-1:PTR_W];
	assign ptr_cur  = meta_cur[PTR_W-1:0];
	assign seen_new = (seen_cur < SEEN_W'(MAX_THRESH)) ? seen_cur + 1'b1 : seen_cur;
	assign ptr_new  = (ptr_cur == PTR_W'(MAX_THRESH - 1)) ? '0 : ptr_cur + 1'b1;
	assign meta_new = {seen_new, ptr_new};

	// clamp the threshold to one..MAX_THRESH
	assign thr_raw = CMP_W'(thresh_q);
	always_comb begin
		priority if (thr_raw == '0) begin
			thr_eff = CMP_W'(1);
		end else if (thr_raw > CMP_W'(MAX_THRESH)) begin
			thr_eff = CMP_W'(MAX_THRESH);
		end else begin
			thr_eff = thr_raw;
		end
	end

	assign thr_m1_p = PTR_W'(thr_eff - 1'b1);
	assign back_ptr = (ptr_cur >= thr_m1_p) ? ptr_cur - thr_m1_p
		: ptr_cur + PTR_W'(MAX_THRESH) - thr_m1_p;

	assign is_report = vld_s1 && op_s1 == OP_REPORT;
	assign filt      = filter_en_q && (sev_s1 < bypass_q);
	assign track     = is_report && filt;
	assign meta_we   = adv && track;
	assign st_we     = adv && track;

	assign st_base    = ST_AW'(ST_AW'(idx_s1) * ST_AW'(MAX_THRESH));
	assign st_wr_addr = st_base + ST_AW'(ptr_cur);
	assign st_rd_addr = st_base + ST_AW'(back_ptr);

	// settle what stage 1 can; a threshold of one always sees its own stamp
	always_comb begin
		res_s1      = 1'b1;
		need_cmp_s1 = 1'b0;
		if (filt) begin
			if (CMP_W'(seen_new) < thr_eff) begin
				res_s1 = 1'b0;
			end else if (thr_eff != CMP_W'(1)) begin
				need_cmp_s1 = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_vld_q  <= '0;
			tag_vld_q <= 1'b0;
		end else if (cfg_wr) begin
			id_vld_q  <= '0;
			tag_vld_q <= 1'b0;
		end else if (adv) begin
			tag_vld_q <= track;
			if (track) begin
				id_vld_q[idx_s1] <= 1'b1;
			end
			if (vld_s1 && op_s1 == OP_CLR_ONE) begin
				id_vld_q[idx_s1] <= 1'b0;
			end
			if (vld_s1 && op_s1 == OP_CLR_ALL) begin
				id_vld_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_idx_q  <= idx_s1;
			tag_meta_q <= meta_new;
		end
	end

	frwf_ram #(
		.WIDTH (TIME_W),
		.DEPTH (ST_DEPTH)
	) u_stamp_ram (
		.clk     (clk),
		.wr_en   (st_we),
		.wr_addr (st_wr_addr),
		.wr_data (now_s1),
		.rd_en   (st_we),
		.rd_addr (st_rd_addr),
		.rd_data (st_rd)
	);

	// stage 2: window compare on modular age
	logic              rvld_s2;
	logic              need_cmp_s2;
	logic              res_s2;
	logic [TIME_W-1:0] now_s2;
	logic [TIME_W-1:0] age;
	logic [TIME_W-1:0] win_eff;
	logic              fwd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_s2 <= 1'b0;
		end else if (adv) begin
			rvld_s2 <= is_report;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			need_cmp_s2 <= need_cmp_s1;
			res_s2      <= res_s1;
			now_s2      <= now_s1;
		end
	end

	assign age     = now_s2 - st_rd;
	assign win_eff = (window_q == '0) ? TIME_W'(1) : window_q;
	assign fwd_s2  = need_cmp_s2 ? (age <= win_eff) : res_s2;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= rvld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fwd_q <= fwd_s2;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {{(OUT_DATA_W - 1){1'b0}}, fwd_q};

endmodule

`default_nettype wire

### design/frwf_checker.sv
// ----------------------------------------------------------------------------
// frwf_checker - port-level checks on the fault rate window filter
// Watches the stream and register ports of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module frwf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [frwf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic                            psel,
	input logic                            penable,
	input logic                            pwrite,
	input logic [frwf_pkg::CFG_ADDR_W-1:0] paddr,
	input logic [frwf_pkg::CFG_DATA_W-1:0] pwdata,
	input logic [frwf_pkg::CFG_DATA_W-1:0] prdata,
	input logic                            pready
);

	import frwf_pkg::*;

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed while stalled");

	// input back-pressure only while the output is blocked
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output back-pressure");

	// only the forward bit carries information
	a_out_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:1] == '0)
		else $error("output padding bits not zero");

	// a filter enable write reads back in the next cycle
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[3:2] == REG_FILTER_EN
		|=> paddr[3:2] != REG_FILTER_EN || prdata[0] == $past(pwdata[0]))
		else $error("filter enable read-back mismatch");

endmodule

bind fault_rate_window_filter_core frwf_checker u_frwf_checker (.*);

`default_nettype wire
